### src/wait_for_deadlock_detector_macros.svh
// Assertion macros used by the detector's sequencer module.
// They expect signals named clk and arst_n in the module that uses them.
`ifndef WAIT_FOR_DEADLOCK_DETECTOR_MACROS_SVH
`define WAIT_FOR_DEADLOCK_DETECTOR_MACROS_SVH

// Same-cycle implication.
`define WFD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define WFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/wfd_pkg.sv
package wfd_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int THREAD_BITS   = 16;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int OP_W          = 3;
	localparam int RES_W         = 32;
	localparam int KIND_W        = 2;
	localparam int STATUS_W      = 2;

	typedef logic [THREAD_BITS-1:0] thread_t;
	typedef logic [RES_W-1:0]       res_t;
	typedef logic [KIND_W-1:0]      kind_t;
	typedef logic [OP_W-1:0]        op_t;
	typedef logic [STATUS_W-1:0]    status_t;

	localparam op_t OP_WAIT       = 3'd0;
	localparam op_t OP_SLEEP      = 3'd1;
	localparam op_t OP_END_SLEEP  = 3'd2;
	localparam op_t OP_CLEAR_WAIT = 3'd3;
	localparam op_t OP_REMOVED    = 3'd4;
	localparam op_t OP_SHUTDOWN   = 3'd5;

	localparam kind_t KIND_NONE   = 2'd0;
	localparam kind_t KIND_OBJECT = 2'd1;
	localparam kind_t KIND_SLEEP  = 2'd2;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_DEADLOCK = 2'd1;
	localparam status_t ST_ARGS     = 2'd2;
	localparam status_t ST_FULL     = 2'd3;

	// Record updates the table can apply to one entry in a cycle.
	typedef enum logic [2:0] {
		WR_NONE,
		WR_WAIT,
		WR_SLEEP,
		WR_WAKE,
		WR_CLEAR,
		WR_MARK
	} wr_op_t;

	typedef struct packed {
		logic [IDX_W-1:0] rd_idx;
		logic [IDX_W-1:0] wr_idx;
		wr_op_t           wr_op;
		logic             alloc;
		thread_t          thread;
		thread_t          waits_on;
		res_t             resource;
		kind_t            kind;
		logic             sleeps_forever;
	} tbl_cmd_t;

	typedef struct packed {
		thread_t          thread;
		thread_t          waits_on;
		res_t             resource;
		kind_t            kind;
		logic             sleeps_forever;
		logic             removed;
		logic [CNT_W-1:0] alloc_cnt;
	} tbl_view_t;

endpackage

### src/wfd_ifs.sv
interface wfd_req_if;
	import wfd_pkg::*;

	logic    valid;
	logic    ready;
	op_t     opcode;
	thread_t requester_thread;
	thread_t holder_thread;
	res_t    resource_id;
	kind_t   resource_type;
	logic    sleep_forever;

	modport source (
		output valid, opcode, requester_thread, holder_thread, resource_id,
			resource_type, sleep_forever,
		input  ready
	);
	modport sink (
		input  valid, opcode, requester_thread, holder_thread, resource_id,
			resource_type, sleep_forever,
		output ready
	);
endinterface

interface wfd_rsp_if;
	import wfd_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	logic    removed_mark;

	modport source (
		output valid, status, removed_mark,
		input  ready
	);
	modport sink (
		input  valid, status, removed_mark,
		output ready
	);
endinterface

### src/wfd_table.sv
module wfd_table (
	input  logic                clk,
	input  logic                arst_n,
	input  wfd_pkg::tbl_cmd_t   cmd,
	output wfd_pkg::tbl_view_t  view
);
	import wfd_pkg::*;

	thread_t          thread_q   [TABLE_ENTRIES];
	thread_t          waits_on_q [TABLE_ENTRIES];
	res_t             resource_q [TABLE_ENTRIES];
	kind_t            kind_q     [TABLE_ENTRIES];
	logic             forever_q  [TABLE_ENTRIES];
	logic             removed_q  [TABLE_ENTRIES];
	logic [CNT_W-1:0] alloc_q;

	// Entries are handed out in order, so the fill count tells which ones hold data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q <= '0;
		end else if (cmd.alloc) begin
			alloc_q <= alloc_q + CNT_W'(1);
		end
	end

	// A fresh entry is written whole, so the stores need no clearing after reset.
	always_ff @(posedge clk) begin
		if (cmd.alloc) begin
			thread_q[cmd.wr_idx]  <= cmd.thread;
			forever_q[cmd.wr_idx] <= 1'b0;
		end
		unique case (cmd.wr_op)
			WR_WAIT: begin
				removed_q[cmd.wr_idx]  <= 1'b0;
				waits_on_q[cmd.wr_idx] <= cmd.waits_on;
				resource_q[cmd.wr_idx] <= cmd.resource;
				kind_q[cmd.wr_idx]     <= cmd.kind;
			end
			WR_SLEEP: begin
				removed_q[cmd.wr_idx]  <= 1'b0;
				waits_on_q[cmd.wr_idx] <= '0;
				resource_q[cmd.wr_idx] <= '0;
				kind_q[cmd.wr_idx]     <= KIND_SLEEP;
				forever_q[cmd.wr_idx]  <= cmd.sleeps_forever;
			end
			WR_WAKE: begin
				kind_q[cmd.wr_idx] <= KIND_NONE;
			end
			WR_CLEAR: begin
				removed_q[cmd.wr_idx]  <= 1'b0;
				waits_on_q[cmd.wr_idx] <= '0;
				resource_q[cmd.wr_idx] <= '0;
				kind_q[cmd.wr_idx]     <= KIND_NONE;
			end
			WR_MARK: begin
				removed_q[cmd.wr_idx] <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign view.thread         = thread_q[cmd.rd_idx];
	assign view.waits_on       = waits_on_q[cmd.rd_idx];
	assign view.resource       = resource_q[cmd.rd_idx];
	assign view.kind           = kind_q[cmd.rd_idx];
	assign view.sleeps_forever = forever_q[cmd.rd_idx];
	assign view.removed        = removed_q[cmd.rd_idx];
	assign view.alloc_cnt      = alloc_q;

endmodule

### src/wfd_seq.sv
module wfd_seq (
	input  logic               clk,
	input  logic               arst_n,
	wfd_req_if.sink            request,
	wfd_rsp_if.source          response,
	output wfd_pkg::tbl_cmd_t  cmd,
	input  wfd_pkg::tbl_view_t view
);
	import wfd_pkg::*;

	`include "wait_for_deadlock_detector_macros.svh"

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_EXEC,
		S_HOP,
		S_CHAIN,
		S_SWEEP,
		S_MARK
	} state_t;

	state_t           state_q;
	op_t              op_q;
	thread_t          req_q;
	thread_t          hold_q;
	res_t             res_q;
	kind_t            rtype_q;
	logic             forever_q;
	thread_t          cur_q;
	logic [CNT_W-1:0] scan_q;
	logic [CNT_W-1:0] hop_q;
	logic [IDX_W-1:0] k_q;
	logic             found_q;
	status_t          status_q;
	logic             out_valid_q;
	status_t          out_status_q;
	logic             out_mark_q;

	thread_t          key;
	logic             hit;
	logic             scan_end;
	logic             full;
	logic [IDX_W-1:0] k_target;
	logic             dl_hop;
	logic             dl_chain;
	logic             chain_hit;

	// The table-entry thread comparator, shared by the requester search and the chain walk.
	assign key       = (state_q == S_CHAIN) ? cur_q : req_q;
	assign hit       = (view.thread == key);
	assign scan_end  = (scan_q == view.alloc_cnt);
	assign full      = !found_q && (view.alloc_cnt == CNT_W'(TABLE_ENTRIES));
	assign k_target  = found_q ? k_q : view.alloc_cnt[IDX_W-1:0];
	assign chain_hit = (state_q == S_CHAIN) && !scan_end && hit;
	assign dl_hop    = (state_q == S_HOP) && (hop_q < view.alloc_cnt) && (cur_q == req_q);
	assign dl_chain  = chain_hit && (view.waits_on == '0) && (view.kind == KIND_SLEEP) &&
		view.sleeps_forever;

	assign request.ready         = (state_q == S_IDLE);
	assign response.valid        = out_valid_q;
	assign response.status       = out_status_q;
	assign response.removed_mark = out_mark_q;

	always_comb begin
		cmd.rd_idx         = scan_q[IDX_W-1:0];
		cmd.wr_idx         = k_target;
		cmd.wr_op          = WR_NONE;
		cmd.alloc          = 1'b0;
		cmd.thread         = req_q;
		cmd.waits_on       = hold_q;
		cmd.resource       = res_q;
		cmd.kind           = rtype_q;
		cmd.sleeps_forever = forever_q;
		unique case (state_q) inside
			S_EXEC: begin
				unique case (op_q) inside
					OP_WAIT: begin
						if ((hold_q != req_q) && !full) begin
							cmd.alloc = !found_q;
							cmd.wr_op = WR_WAIT;
						end
					end
					OP_SLEEP: begin
						if (!full) begin
							cmd.alloc = !found_q;
							cmd.wr_op = WR_SLEEP;
						end
					end
					OP_END_SLEEP: begin
						if (found_q) begin
							cmd.wr_op = WR_WAKE;
						end
					end
					OP_CLEAR_WAIT, OP_SHUTDOWN: begin
						if (found_q) begin
							cmd.wr_op = WR_CLEAR;
						end
					end
					default: begin
					end
				endcase
			end
			S_SWEEP: begin
				cmd.wr_idx = scan_q[IDX_W-1:0];
				if (!scan_end && (view.resource == res_q) && (view.kind == KIND_OBJECT)) begin
					cmd.wr_op = WR_MARK;
				end
			end
			S_HOP, S_CHAIN: begin
				if (dl_hop || dl_chain) begin
					cmd.wr_op = WR_CLEAR;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= '0;
			req_q        <= '0;
			hold_q       <= '0;
			res_q        <= '0;
			rtype_q      <= '0;
			forever_q    <= 1'b0;
			cur_q        <= '0;
			scan_q       <= '0;
			hop_q        <= '0;
			k_q          <= '0;
			found_q      <= 1'b0;
			status_q     <= ST_OK;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_mark_q   <= 1'b0;
		end else begin
			if (response.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (request.valid) begin
						op_q      <= request.opcode;
						req_q     <= request.requester_thread;
						hold_q    <= request.holder_thread;
						res_q     <= request.resource_id;
						rtype_q   <= request.resource_type;
						forever_q <= request.sleep_forever;
						found_q   <= 1'b0;
						scan_q    <= '0;
						status_q  <= ST_OK;
						if (request.requester_thread != '0) begin
							state_q <= S_FIND;
						end else if (request.opcode == OP_REMOVED) begin
							state_q <= S_SWEEP;
						end else begin
							status_q <= ST_ARGS;
							state_q  <= S_MARK;
						end
					end
				end
				S_FIND: begin
					if (scan_end) begin
						found_q <= 1'b0;
						state_q <= S_EXEC;
					end else if (hit) begin
						found_q <= 1'b1;
						k_q     <= scan_q[IDX_W-1:0];
						state_q <= S_EXEC;
					end else begin
						scan_q <= scan_q + CNT_W'(1);
					end
				end
				S_EXEC: begin
					scan_q <= CNT_W'(k_target);
					unique case (op_q) inside
						OP_WAIT: begin
							if (hold_q == req_q) begin
								status_q <= ST_ARGS;
								state_q  <= S_MARK;
							end else if (full) begin
								status_q <= ST_FULL;
								state_q  <= S_MARK;
							end else begin
								found_q <= 1'b1;
								k_q     <= k_target;
								cur_q   <= hold_q;
								hop_q   <= '0;
								state_q <= S_HOP;
							end
						end
						OP_SLEEP: begin
							if (full) begin
								status_q <= ST_FULL;
							end else begin
								found_q <= 1'b1;
								k_q     <= k_target;
							end
							state_q <= S_MARK;
						end
						OP_END_SLEEP, OP_CLEAR_WAIT, OP_SHUTDOWN: begin
							state_q <= S_MARK;
						end
						OP_REMOVED: begin
							scan_q  <= '0;
							state_q <= S_SWEEP;
						end
						default: begin
							status_q <= ST_ARGS;
							state_q  <= S_MARK;
						end
					endcase
				end
				S_HOP: begin
					if (hop_q >= view.alloc_cnt) begin
						scan_q  <= CNT_W'(k_q);
						state_q <= S_MARK;
					end else if (dl_hop) begin
						status_q <= ST_DEADLOCK;
						scan_q   <= CNT_W'(k_q);
						state_q  <= S_MARK;
					end else begin
						scan_q  <= '0;
						state_q <= S_CHAIN;
					end
				end
				S_CHAIN: begin
					if (scan_end) begin
						scan_q  <= CNT_W'(k_q);
						state_q <= S_MARK;
					end else if (chain_hit) begin
						if (view.waits_on != '0) begin
							cur_q   <= view.waits_on;
							hop_q   <= hop_q + CNT_W'(1);
							state_q <= S_HOP;
						end else begin
							if (dl_chain) begin
								status_q <= ST_DEADLOCK;
							end
							scan_q  <= CNT_W'(k_q);
							state_q <= S_MARK;
						end
					end else begin
						scan_q <= scan_q + CNT_W'(1);
					end
				end
				S_SWEEP: begin
					if (scan_end) begin
						scan_q  <= CNT_W'(k_q);
						state_q <= S_MARK;
					end else begin
						scan_q <= scan_q + CNT_W'(1);
					end
				end
				S_MARK: begin
					if (!out_valid_q || response.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_mark_q   <= found_q & view.removed;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`WFD_ASSERT_IMPL(a_deadlock_from_wait, (state_q == S_MARK) && (status_q == ST_DEADLOCK), (op_q == OP_WAIT), "deadlock status on an operation other than wait request")
	`WFD_ASSERT_IMPL(a_scan_in_table, (state_q == S_FIND) || (state_q == S_CHAIN) || (state_q == S_SWEEP), (scan_q <= view.alloc_cnt), "scan index ran past the allocated entries")
	`WFD_ASSERT_IMPL(a_alloc_has_room, cmd.alloc, (view.alloc_cnt < CNT_W'(TABLE_ENTRIES)), "entry allocated in a full table")
	`WFD_ASSERT_NEXT(a_alloc_counts, cmd.alloc, (view.alloc_cnt == $past(view.alloc_cnt) + CNT_W'(1)), "allocation did not advance the fill count")

endmodule

### src/wait_for_deadlock_detector.sv
// Channel   Modport  Direction  Contents
// request   sink     in         opcode, requester, holder, resource, type, sleep mark
// response  source   out        status, removed mark of the requester's entry
//
// Every request is handled by one thread comparator that visits one table entry per
// cycle. A zero requester is refused straight away unless it is a removal notice;
// the longest request is a wait whose holder chain runs one hop per allocated entry.
// The block takes no new request while one is in work; a finished response sits in an
// output register, so a new request is accepted while the previous response is unread.
// Reset clears the fill count and the control state; table entries need no clearing.
module wait_for_deadlock_detector (
	input logic       clk,
	input logic       arst_n,
	wfd_req_if.sink   request,
	wfd_rsp_if.source response
);
	import wfd_pkg::*;

	// Commands from the sequencer into the table, and the entry it currently points at.
	tbl_cmd_t  tbl_cmd;
	tbl_view_t tbl_view;

	// The sequencer looks the requester up, applies the operation, walks the holder
	// chain for deadlock one hop at a time and finally reads the requester's removed
	// mark for the response.
	wfd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.response (response),
		.cmd      (tbl_cmd),
		.view     (tbl_view)
	);

	// The table holds one wait record per thread, filled in order and never freed.
	wfd_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (tbl_cmd),
		.view   (tbl_view)
	);

endmodule

### tb/wfd_tb_pkg.sv
package wfd_tb_pkg;
	import wfd_pkg::*;

	// Opcodes the block does not define; it answers them with bad arguments.
	localparam op_t   OP_SPARE_LO = 3'd6;
	localparam op_t   OP_SPARE_HI = 3'd7;
	localparam kind_t KIND_OTHER  = 2'd3;

	typedef struct {
		op_t     opcode;
		thread_t requester;
		thread_t holder;
		res_t    resource;
		kind_t   kind;
		logic    sleeps_forever;
	} wait_request_t;

	typedef struct {
		status_t status;
		logic    removed_mark;
	} wait_outcome_t;

	// Shadow copy of the wait table plus the outcomes still owed by the block.
	class deadlock_book;
		thread_t       owner[TABLE_ENTRIES];
		thread_t       waits_on[TABLE_ENTRIES];
		res_t          blocked_on[TABLE_ENTRIES];
		kind_t         kind[TABLE_ENTRIES];
		bit            asleep_forever[TABLE_ENTRIES];
		bit            removed[TABLE_ENTRIES];
		int            used;
		wait_outcome_t awaited[$];
		int unsigned   failures;
		int unsigned   seen[4];
		int unsigned   marks_seen;

		function new();
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				owner[i]          = '0;
				waits_on[i]       = '0;
				blocked_on[i]     = '0;
				kind[i]           = KIND_NONE;
				asleep_forever[i] = 1'b0;
				removed[i]        = 1'b0;
			end
			for (int s = 0; s < 4; s++)
				seen[s] = 0;
			used       = 0;
			failures   = 0;
			marks_seen = 0;
		endfunction

		function int slot_of(thread_t t);
			for (int i = 0; i < used; i++)
				if (owner[i] == t)
					return i;
			return -1;
		endfunction

		// Entries are handed out in order and never given back.
		function int claim_slot(thread_t t);
			int k;
			k = slot_of(t);
			if (k >= 0 || used >= TABLE_ENTRIES)
				return k;
			owner[used] = t;
			used++;
			return used - 1;
		endfunction

		function void clear_record(int k);
			removed[k]    = 1'b0;
			blocked_on[k] = '0;
			kind[k]       = KIND_NONE;
			waits_on[k]   = '0;
		endfunction

		// Walks the holder chain for at most as many hops as there are entries in use.
		function bit closes_cycle(thread_t requester, thread_t holder);
			thread_t cur;
			int      k;
			cur = holder;
			for (int hop = 0; hop < used; hop++) begin
				if (cur == requester)
					return 1'b1;
				k = slot_of(cur);
				if (k < 0)
					return 1'b0;
				if (waits_on[k] == '0)
					return kind[k] == KIND_SLEEP && asleep_forever[k];
				cur = waits_on[k];
			end
			return 1'b0;
		endfunction

		function wait_outcome_t apply(wait_request_t rq);
			wait_outcome_t o;
			int            k;
			o.status = ST_OK;
			if (rq.opcode > OP_SHUTDOWN || (rq.requester == '0 && rq.opcode != OP_REMOVED)) begin
				o.status = ST_ARGS;
			end else begin
				case (rq.opcode)
					OP_WAIT: begin
						if (rq.holder == rq.requester) begin
							o.status = ST_ARGS;
						end else begin
							k = claim_slot(rq.requester);
							if (k < 0) begin
								o.status = ST_FULL;
							end else begin
								removed[k]    = 1'b0;
								waits_on[k]   = rq.holder;
								blocked_on[k] = rq.resource;
								kind[k]       = rq.kind;
								if (closes_cycle(rq.requester, rq.holder)) begin
									clear_record(k);
									o.status = ST_DEADLOCK;
								end
							end
						end
					end
					OP_SLEEP: begin
						k = claim_slot(rq.requester);
						if (k < 0) begin
							o.status = ST_FULL;
						end else begin
							removed[k]        = 1'b0;
							waits_on[k]       = '0;
							blocked_on[k]     = '0;
							kind[k]           = KIND_SLEEP;
							asleep_forever[k] = rq.sleeps_forever;
						end
					end
					OP_END_SLEEP: begin
						k = slot_of(rq.requester);
						if (k >= 0)
							kind[k] = KIND_NONE;
					end
					OP_CLEAR_WAIT, OP_SHUTDOWN: begin
						k = slot_of(rq.requester);
						if (k >= 0)
							clear_record(k);
					end
					OP_REMOVED: begin
						for (int i = 0; i < used; i++)
							if (blocked_on[i] == rq.resource && kind[i] == KIND_OBJECT)
								removed[i] = 1'b1;
					end
					default: begin
					end
				endcase
			end
			k = (rq.requester != '0) ? slot_of(rq.requester) : -1;
			o.removed_mark = (k >= 0) ? removed[k] : 1'b0;
			return o;
		endfunction

		function void note_request(wait_request_t rq);
			awaited = {awaited, apply(rq)};
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void check_response(status_t status, logic mark);
			wait_outcome_t want;
			if (awaited.size() == 0) begin
				$error("response with no request outstanding: status %0d, removed_mark %0b",
					status, mark);
				failures++;
				return;
			end
			want = awaited.pop_front();
			seen[want.status]++;
			if (want.removed_mark)
				marks_seen++;
			if (status !== want.status) begin
				$error("status mismatch: expected %0d, actual %0d", want.status, status);
				failures++;
			end
			if (mark !== want.removed_mark) begin
				$error("removed_mark mismatch: expected %0b, actual %0b",
					want.removed_mark, mark);
				failures++;
			end
		endfunction
	endclass

endpackage

### tb/wait_for_deadlock_detector_tb.sv
module wait_for_deadlock_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wfd_pkg::*;
	import wfd_tb_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int RESET_CYCLES   = 8;
	localparam int RANDOM_ITEMS   = 800;
	localparam int CREW_SIZE      = 15;
	// Strangers may only appear once the crew has had a chance to take its entries.
	localparam int STRANGERS_FROM = 200;
	localparam int DRAIN_AT       = 450;
	localparam int HOLD_OFF_AFTER = 300;
	localparam int HOLD_OFF       = 600;
	// The longest request is a wait whose holder chain walks a full table.
	localparam int SETTLE_CYCLES  = 400;
	localparam int TIMEOUT_CYCLES = 1_200_000;
	localparam int MAX_IDLE       = 8;

	logic clk = 1'b0;
	logic arst_n;

	wfd_req_if req_ch ();
	wfd_rsp_if rsp_ch ();

	wait_for_deadlock_detector dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (req_ch),
		.response (rsp_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	deadlock_book book = new();

	// Threads that the random part mostly works with. There are fewer of them than
	// table entries, so the crew never locks itself out; the one spare entry goes to
	// the first stranger to wait or sleep, and every later one then meets a full table.
	thread_t crew[CREW_SIZE];

	// Each side switches now and then between idling at random and running flat out,
	// so that the run has stretches with no gaps at all as well.
	bit sender_calm   = 1'b0;
	bit receiver_calm = 1'b0;

	function automatic int draw_gap(bit calm);
		return calm ? 0 : $urandom_range(0, MAX_IDLE);
	endfunction

	// Called at a falling edge and returns at the falling edge after the request was
	// taken. The valid line is left high so that a request that follows straight on
	// keeps it high rather than dropping and raising it in the same time step.
	task automatic drive_request(input wait_request_t rq);
		int gap;
		if ($urandom_range(0, 31) == 0)
			sender_calm = !sender_calm;
		gap = draw_gap(sender_calm);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid            <= 1'b1;
		req_ch.opcode           <= rq.opcode;
		req_ch.requester_thread <= rq.requester;
		req_ch.holder_thread    <= rq.holder;
		req_ch.resource_id      <= rq.resource;
		req_ch.resource_type    <= rq.kind;
		req_ch.sleep_forever    <= rq.sleeps_forever;
		do
			@(posedge clk);
		while (!req_ch.ready);
		book.note_request(rq);
		@(negedge clk);
	endtask

	// Random request. Most go to crew threads so that wait chains, cycles and
	// indefinite sleepers build up; a few carry a zero requester, a stranger, a holder
	// of nobody, a holder equal to the requester or an unknown holder. Resources come
	// mostly from a handful of values so that removal notices find their waiters.
	function automatic wait_request_t roll_request(bit strangers);
		wait_request_t rq;
		int            pick;
		res_t          shared_res[6];
		shared_res = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
			32'h8000_0000, 32'h5A5A_A5A5, 32'h0000_0007};

		pick = $urandom_range(0, 99);
		if (pick < 38)
			rq.opcode = OP_WAIT;
		else if (pick < 52)
			rq.opcode = OP_SLEEP;
		else if (pick < 62)
			rq.opcode = OP_END_SLEEP;
		else if (pick < 72)
			rq.opcode = OP_CLEAR_WAIT;
		else if (pick < 86)
			rq.opcode = OP_REMOVED;
		else if (pick < 92)
			rq.opcode = OP_SHUTDOWN;
		else
			rq.opcode = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;

		pick = $urandom_range(0, 99);
		if (pick < 3)
			rq.requester = '0;
		else if (pick < 8 && strangers)
			rq.requester = thread_t'($urandom_range(1, 16'hFFFF));
		else
			rq.requester = crew[$urandom_range(0, CREW_SIZE - 1)];

		pick = $urandom_range(0, 99);
		if (pick < 6)
			rq.holder = '0;
		else if (pick < 12)
			rq.holder = rq.requester;
		else if (pick < 18)
			rq.holder = thread_t'($urandom);
		else
			rq.holder = crew[$urandom_range(0, CREW_SIZE - 1)];

		if ($urandom_range(0, 99) < 70)
			rq.resource = shared_res[$urandom_range(0, 5)];
		else
			rq.resource = res_t'($urandom);

		if ($urandom_range(0, 1))
			rq.kind = KIND_OBJECT;
		else
			rq.kind = kind_t'($urandom_range(0, 3));

		rq.sleeps_forever = 1'($urandom_range(0, 1));
		return rq;
	endfunction

	// Response side: draws a stall for every response and, once, after a few hundred
	// responses, holds ready low for a long stretch while the sender keeps offering
	// requests, so that the output register fills and the block stops taking input.
	initial begin
		int stall;
		int taken;
		taken        = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				receiver_calm = !receiver_calm;
			stall = (taken == HOLD_OFF_AFTER) ? HOLD_OFF : draw_gap(receiver_calm);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!rsp_ch.valid);
			book.check_response(rsp_ch.status, rsp_ch.removed_mark);
			taken++;
			@(negedge clk);
		end
	end

	// Safety net against a hung handshake.
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$error("timed out with %0d responses outstanding", book.pending());
		$display("wait_for_deadlock_detector_tb failed");
		$finish;
	end

	initial begin
		thread_t cand;
		bit      clash;

		req_ch.valid            = 1'b0;
		req_ch.opcode           = OP_WAIT;
		req_ch.requester_thread = '0;
		req_ch.holder_thread    = '0;
		req_ch.resource_id      = '0;
		req_ch.resource_type    = KIND_NONE;
		req_ch.sleep_forever    = 1'b0;
		arst_n                  = 1'b0;

		// The directed requests below use the first seven crew threads; the rest are
		// drawn at random, distinct from each other and from zero.
		crew[0] = 16'h0001;
		crew[1] = 16'h0002;
		crew[2] = 16'hFFFF;
		crew[3] = 16'h0003;
		crew[4] = 16'h0004;
		crew[5] = 16'h0005;
		crew[6] = 16'h8000;
		for (int i = 7; i < CREW_SIZE; i++) begin
			do begin
				cand  = thread_t'($urandom_range(6, 16'hFFFE));
				clash = 1'b0;
				for (int j = 0; j < i; j++)
					if (crew[j] == cand)
						clash = 1'b1;
			end while (clash);
			crew[i] = cand;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Undefined opcodes, one of them with every field at its all-ones extreme.
		drive_request(wait_request_t'{OP_SPARE_LO, 16'h0001, 16'h0000, 32'h0, KIND_NONE, 1'b0});
		drive_request(wait_request_t'{OP_SPARE_HI, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
			KIND_OTHER, 1'b1});
		// A zero requester is refused for everything but a removal notice.
		drive_request(wait_request_t'{OP_WAIT, 16'h0000, 16'h0002, 32'h0, KIND_OBJECT, 1'b0});
		drive_request(wait_request_t'{OP_SLEEP, 16'h0000, 16'h0000, 32'h0, KIND_NONE, 1'b1});
		// Thread 5 has no entry yet: these leave the table alone and answer ok.
		drive_request(wait_request_t'{OP_END_SLEEP, 16'h0005, 16'h0000, 32'h0, KIND_NONE, 1'b0});
		drive_request(wait_request_t'{OP_CLEAR_WAIT, 16'h0005, 16'h0000, 32'h0, KIND_NONE,
			1'b0});
		drive_request(wait_request_t'{OP_SHUTDOWN, 16'h0005, 16'h0000, 32'h0, KIND_NONE, 1'b0});
		// Waiting on oneself is bad arguments.
		drive_request(wait_request_t'{OP_WAIT, 16'hFFFF, 16'hFFFF, 32'h0, KIND_OBJECT, 1'b0});
		// 1 waits on 2, then 2 on 1 closes a two-thread cycle.
		drive_request(wait_request_t'{OP_WAIT, 16'h0001, 16'h0002, 32'hFFFF_FFFF, KIND_OBJECT,
			1'b0});
		drive_request(wait_request_t'{OP_WAIT, 16'h0002, 16'h0001, 32'h0, KIND_OBJECT, 1'b0});
		// Removal of the resource 1 waits on, announced by nobody and then by thread 1.
		drive_request(wait_request_t'{OP_REMOVED, 16'h0000, 16'h0000, 32'hFFFF_FFFF,
			KIND_NONE, 1'b0});
		drive_request(wait_request_t'{OP_REMOVED, 16'h0001, 16'h0000, 32'hFFFF_FFFF,
			KIND_NONE, 1'b0});
		// Waiting on an indefinite sleeper is a deadlock until the sleep ends.
		drive_request(wait_request_t'{OP_SLEEP, 16'hFFFF, 16'h0000, 32'h0, KIND_NONE, 1'b1});
		drive_request(wait_request_t'{OP_WAIT, 16'h0003, 16'hFFFF, 32'h8000_0000, KIND_OTHER,
			1'b0});
		drive_request(wait_request_t'{OP_END_SLEEP, 16'hFFFF, 16'h0000, 32'h0, KIND_NONE, 1'b0});
		drive_request(wait_request_t'{OP_WAIT, 16'h0003, 16'hFFFF, 32'h0, KIND_OBJECT, 1'b0});
		// A wait on no thread, of sleep kind, and a wait behind it that must not deadlock.
		drive_request(wait_request_t'{OP_WAIT, 16'h0004, 16'h0000, 32'h0000_1234, KIND_SLEEP,
			1'b0});
		drive_request(wait_request_t'{OP_WAIT, 16'h0005, 16'h0004, 32'h0, KIND_NONE, 1'b0});
		// Thread 1 waits again through a longer chain; its removed mark goes away.
		drive_request(wait_request_t'{OP_WAIT, 16'h0001, 16'h0003, 32'h0, KIND_OBJECT, 1'b0});
		drive_request(wait_request_t'{OP_CLEAR_WAIT, 16'h0001, 16'h0000, 32'h0, KIND_NONE,
			1'b0});
		drive_request(wait_request_t'{OP_SHUTDOWN, 16'h0003, 16'h0000, 32'h0, KIND_NONE, 1'b0});
		// A timed sleeper blocks nobody; once it waits back on its waiter it deadlocks.
		drive_request(wait_request_t'{OP_SLEEP, 16'h8000, 16'h0000, 32'h0, KIND_NONE, 1'b0});
		drive_request(wait_request_t'{OP_WAIT, 16'h0002, 16'h8000, 32'h0, KIND_OBJECT, 1'b0});
		drive_request(wait_request_t'{OP_WAIT, 16'h8000, 16'h0002, 32'h0, KIND_OBJECT, 1'b0});

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Once in the run the sender stops until every owed response is in, so the
			// block also starts again from a fully idle state.
			if (n == DRAIN_AT) begin
				req_ch.valid <= 1'b0;
				do
					@(negedge clk);
				while (book.pending() != 0);
			end
			drive_request(roll_request(n >= STRANGERS_FROM));
		end
		req_ch.valid <= 1'b0;

		while (book.pending() != 0)
			@(negedge clk);
		// Anything the block still sends now has no request behind it.
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Responses: %0d ok, %0d deadlock, %0d bad arguments, %0d table full",
			book.seen[ST_OK], book.seen[ST_DEADLOCK], book.seen[ST_ARGS], book.seen[ST_FULL]);
		$display("Responses with the removed mark set: %0d; table entries in use: %0d of %0d",
			book.marks_seen, book.used, TABLE_ENTRIES);
		if (book.failures == 0)
			$display("wait_for_deadlock_detector_tb passed");
		else
			$display("wait_for_deadlock_detector_tb failed");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/wfd_pkg.sv
src/wfd_ifs.sv
src/wfd_table.sv
src/wfd_seq.sv
src/wait_for_deadlock_detector.sv
tb/wfd_tb_pkg.sv
tb/wait_for_deadlock_detector_tb.sv
